// ----- rtl/core/stack_alu_unit_assert.svh -----
// ---------------------------------------------------------------------------
// stack_alu_unit assertion macros
// Shared forms for the concurrent checks of the stack ALU unit.
// ---------------------------------------------------------------------------
`ifndef STACK_ALU_UNIT_ASSERT_SVH
`define STACK_ALU_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAU_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAU_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/sau_pkg.sv -----
// ---------------------------------------------------------------------------
// sau_pkg
// Types, codes and sizes shared by the stack ALU unit modules.
// ---------------------------------------------------------------------------
package sau_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    // The top entry lives in a register, so the memory holds one entry less.
    localparam int MEM_DEPTH   = STACK_DEPTH - 1;
    localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DEPTH_OUT_W = 7;
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        MODE_PUSH = 3'd0,
        MODE_POP  = 3'd1,
        MODE_SWAP = 3'd2,
        MODE_SUB  = 3'd3,
        MODE_MUL  = 3'd4,
        MODE_DIV  = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FEW     = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SRC_MEM = 2'd0,
        SRC_SUB = 2'd1,
        SRC_MUL = 2'd2,
        SRC_DIV = 2'd3
    } t_top_src;

    typedef struct packed {
        t_mode              mode;
        logic signed [31:0] push_value;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] top_value;
        logic               top_valid;
        logic [6:0]         depth_after;
    } t_out;

    // Controller to datapath.
    typedef struct packed {
        logic     push;
        logic     dec;
        logic     wr_top;
        logic     ld_top;
        t_top_src top_src;
        logic     div_start;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic empty;
        logic few;
        logic full;
        logic top_zero;
        logic div_done;
    } t_stat;

endpackage

// ----- rtl/core/stack_alu_unit.sv -----
// ---------------------------------------------------------------------------
// stack_alu_unit
// Bounded stack of 32-bit integers with push, pop, swap, sub, mul and div.
// ---------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------
//  command   | start, busy           | i_in  (mode, push_value)
//  result    | o_done (one cycle)    | o_out (status, top_value,
//            |                       |        top_valid, depth_after)
//
// Push, pop of the last entry and every rejected command strobe o_done in
// the cycle after acceptance. Pop, swap, sub and mul pass through S_EXEC
// for the registered read of the word below the top. Div also passes
// through S_EXEC, then waits in S_DIVW for the one-bit-per-cycle divider.
// Reset is synchronous; the stack comes up empty and needs no clearing.
// busy is high from acceptance through the result strobe; the receiver
// cannot stall the result.
`include "stack_alu_unit_assert.svh"

module stack_alu_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sau_pkg::t_in  i_in,
    output logic          o_done,
    output sau_pkg::t_out o_out
);
    import sau_pkg::*;

    t_cmd    cmd;
    t_stat   stat;
    t_status status;
    logic [31:0] top_value;
    logic        top_valid;
    logic [6:0]  depth;

    sau_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_in.mode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_status (status),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    sau_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_push_value (i_in.push_value),
        .o_stat       (stat),
        .o_top_value  (top_value),
        .o_top_valid  (top_valid),
        .o_depth      (depth)
    );

    assign o_out.status      = status;
    assign o_out.top_value   = top_value;
    assign o_out.top_valid   = top_valid;
    assign o_out.depth_after = depth;

    `SAU_CHECK_NEXT(a_busy_after_accept, start && !busy, busy, "busy low after a command word was taken")
    `SAU_CHECK_NEXT(a_single_strobe, o_done, !o_done, "result strobe held longer than one cycle")
    `SAU_CHECK_NOW(a_full_depth, o_done && (o_out.status == ST_FULL), o_out.depth_after == 7'(STACK_DEPTH), "full status with a stack that is not full")
    `SAU_CHECK_NOW(a_few_depth, o_done && (o_out.status == ST_FEW), o_out.depth_after < 7'd2, "too-few status with two or more entries")

endmodule

// ----- rtl/core/sau_div.sv -----
// ---------------------------------------------------------------------------
// sau_div
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// ---------------------------------------------------------------------------
module sau_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sau_pkg::DATA_W-1:0] i_dividend,
    input  logic [sau_pkg::DATA_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [sau_pkg::DATA_W-1:0] o_quot
);
    import sau_pkg::*;

    logic                 r_run;
    logic                 r_fin;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_neg;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_den;

    logic [DATA_W:0]      shifted;
    logic                 fits;
    logic [DATA_W-1:0]    mag_a;
    logic [DATA_W-1:0]    mag_b;

    assign mag_a   = i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign mag_b   = i_divisor[DATA_W-1]  ? (~i_divisor + 1'b1)  : i_divisor;
    assign shifted = {r_rem, r_quo[DATA_W-1]};
    assign fits    = (shifted >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_fin <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= mag_a;
            r_den <= mag_b;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_run) begin
            r_rem <= fits ? DATA_W'(shifted - {1'b0, r_den}) : shifted[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], fits};
        end
    end

    // The most negative value divided by minus one comes out as itself.
    assign o_quot = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_done = r_fin;

endmodule

// ----- rtl/core/sau_dpath.sv -----
// ---------------------------------------------------------------------------
// sau_dpath
// Stack storage, top-of-stack register, entry count and arithmetic.
// ---------------------------------------------------------------------------
module sau_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sau_pkg::t_cmd                 i_cmd,
    input  logic [31:0]                   i_push_value,
    output sau_pkg::t_stat                o_stat,
    output logic [31:0]                   o_top_value,
    output logic                          o_top_valid,
    output logic [6:0]                    o_depth
);
    import sau_pkg::*;

    // Entries below the top word; the top word is held in r_top.
    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] r_top;
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] n_top;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              wr_en;
    logic              empty;
    logic              div_done;
    logic [DATA_W-1:0] div_quot;

    assign empty   = (r_count == '0);
    assign rd_addr = ADDR_W'(r_count - CNT_W'(2));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = rd_addr;
        wr_data = r_top;
        if (i_cmd.push) begin
            // The old top moves down into memory.
            wr_en   = !empty;
            wr_addr = ADDR_W'(r_count - CNT_W'(1));
        end else if (i_cmd.wr_top) begin
            wr_en   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    sau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rdata),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        unique case (i_cmd.top_src)
            SRC_MEM: n_top = r_rdata;
            SRC_SUB: n_top = r_rdata - r_top;
            SRC_MUL: n_top = DATA_W'(r_rdata * r_top);
            SRC_DIV: n_top = div_quot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top <= i_push_value;
        end else if (i_cmd.ld_top) begin
            r_top <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.dec) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    assign o_stat.empty    = empty;
    assign o_stat.few      = (r_count < CNT_W'(2));
    assign o_stat.full     = (r_count == CNT_W'(STACK_DEPTH));
    assign o_stat.top_zero = (r_top == '0);
    assign o_stat.div_done = div_done;

    assign o_top_value = empty ? '0 : r_top;
    assign o_top_valid = !empty;
    assign o_depth     = DEPTH_OUT_W'(r_count);

endmodule

// ----- rtl/core/sau_ctrl.sv -----
// ---------------------------------------------------------------------------
// sau_ctrl
// Sequencer of the stack ALU unit: checks, datapath commands and status.
// ---------------------------------------------------------------------------
module sau_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  sau_pkg::t_mode   i_mode,
    input  sau_pkg::t_stat   i_stat,
    output sau_pkg::t_cmd    o_cmd,
    output sau_pkg::t_status o_status,
    output logic             o_busy,
    output logic             o_done
);
    import sau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIVW = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_mode   r_mode;
    t_mode   n_mode;
    t_status r_status;
    t_status n_status;

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.top_src = SRC_MEM;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_mode   = i_mode;
                    n_status = ST_OK;
                    n_state  = S_RESP;
                    unique case (i_mode)
                        MODE_PUSH: begin
                            if (i_stat.full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        MODE_POP: begin
                            if (i_stat.empty) begin
                                n_status = ST_EMPTY;
                            end else if (i_stat.few) begin
                                o_cmd.dec = 1'b1;
                            end else begin
                                n_state = S_EXEC;
                            end
                        end
                        MODE_SWAP, MODE_SUB, MODE_MUL: begin
                            if (i_stat.few) begin
                                n_status = ST_FEW;
                            end else begin
                                n_state = S_EXEC;
                            end
                        end
                        MODE_DIV: begin
                            if (i_stat.few) begin
                                n_status = ST_FEW;
                            end else if (i_stat.top_zero) begin
                                n_status = ST_DIVZERO;
                            end else begin
                                n_state = S_EXEC;
                            end
                        end
                        default: begin
                            // Unused opcodes leave the stack alone.
                        end
                    endcase
                end
            end
            S_EXEC: begin
                // The word below the top is now in the memory read register.
                n_state = S_RESP;
                unique case (r_mode)
                    MODE_POP: begin
                        o_cmd.ld_top = 1'b1;
                        o_cmd.dec    = 1'b1;
                    end
                    MODE_SWAP: begin
                        o_cmd.ld_top = 1'b1;
                        o_cmd.wr_top = 1'b1;
                    end
                    MODE_SUB: begin
                        o_cmd.ld_top  = 1'b1;
                        o_cmd.top_src = SRC_SUB;
                        o_cmd.dec     = 1'b1;
                    end
                    MODE_MUL: begin
                        o_cmd.ld_top  = 1'b1;
                        o_cmd.top_src = SRC_MUL;
                        o_cmd.dec     = 1'b1;
                    end
                    MODE_DIV: begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIVW;
                    end
                    default: begin
                    end
                endcase
            end
            S_DIVW: begin
                o_cmd.top_src = SRC_DIV;
                if (i_stat.div_done) begin
                    o_cmd.ld_top = 1'b1;
                    o_cmd.dec    = 1'b1;
                    n_state      = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_PUSH;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_status <= n_status;
        end
    end

    assign o_status = r_status;
    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = (r_state == S_RESP);

endmodule

// ----- sim/stack_alu_unit_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stack_alu_unit_checker
// Watches the command and result channels of the stack ALU unit, keeps its
// own copy of the stack, and compares every result word field by field with
// the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module stack_alu_unit_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           busy,
    input  sau_pkg::t_in   i_in,
    input  logic           o_done,
    input  sau_pkg::t_out  o_out,
    output int             o_errors,
    output int             o_pending
);
    import sau_pkg::*;

    logic [31:0] stack_mirror [STACK_DEPTH];
    int          entry_total = 0;
    t_out        outcome_queue [$];

    task automatic report(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        o_errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            report($sformatf("%s expected %0h got %0h", name, want, got));
        end
    endtask

    // Magnitudes are divided unsigned, then the sign is applied, so the most
    // negative value divided by minus one wraps back to itself.
    function automatic logic [31:0] trunc_quotient(input logic [31:0] num,
                                                   input logic [31:0] den);
        logic [31:0] mag_n;
        logic [31:0] mag_d;
        logic [31:0] q;
        mag_n = num[31] ? -num : num;
        mag_d = den[31] ? -den : den;
        q = mag_n / mag_d;
        if (num[31] ^ den[31]) begin
            q = -q;
        end
        return q;
    endfunction

    task automatic apply_stack_op(input t_in word, output t_out outcome);
        logic [31:0] top_entry;
        logic [31:0] below_entry;
        logic [31:0] combined;
        t_status     st;
        st = ST_OK;
        case (word.mode)
            MODE_PUSH: begin
                if (entry_total >= STACK_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    stack_mirror[entry_total] = word.push_value;
                    entry_total++;
                end
            end
            MODE_POP: begin
                if (entry_total == 0) begin
                    st = ST_EMPTY;
                end else begin
                    entry_total--;
                end
            end
            MODE_SWAP, MODE_SUB, MODE_MUL, MODE_DIV: begin
                if (entry_total < 2) begin
                    st = ST_FEW;
                end else begin
                    top_entry   = stack_mirror[entry_total - 1];
                    below_entry = stack_mirror[entry_total - 2];
                    if (word.mode == MODE_SWAP) begin
                        stack_mirror[entry_total - 1] = below_entry;
                        stack_mirror[entry_total - 2] = top_entry;
                    end else if (word.mode == MODE_DIV && top_entry == 32'd0) begin
                        st = ST_DIVZERO;
                    end else begin
                        if (word.mode == MODE_SUB) begin
                            combined = below_entry - top_entry;
                        end else if (word.mode == MODE_MUL) begin
                            combined = below_entry * top_entry;
                        end else begin
                            combined = trunc_quotient(below_entry, top_entry);
                        end
                        stack_mirror[entry_total - 2] = combined;
                        entry_total--;
                    end
                end
            end
            default: begin
                // Unused opcodes leave the stack alone and report success.
            end
        endcase
        outcome.status      = st;
        outcome.top_valid   = (entry_total > 0);
        outcome.top_value   = (entry_total > 0) ? stack_mirror[entry_total - 1] : 32'd0;
        outcome.depth_after = entry_total[6:0];
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (outcome_queue.size() == 0) begin
                    report("result word with no command outstanding");
                end else begin
                    want = outcome_queue.pop_front();
                    check_field("status", 32'(want.status), 32'(o_out.status));
                    check_field("top_value", want.top_value, o_out.top_value);
                    check_field("top_valid", 32'(want.top_valid), 32'(o_out.top_valid));
                    check_field("depth_after", 32'(want.depth_after),
                                32'(o_out.depth_after));
                end
            end
            if (start && !busy) begin
                apply_stack_op(i_in, want);
                outcome_queue.push_back(want);
            end
        end
        o_pending <= outcome_queue.size();
    end

endmodule

// ----- sim/stack_alu_unit_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stack_alu_unit_test
// Drives the stack ALU unit with a short directed sequence covering the
// empty, too-few and divide-by-zero codes and arithmetic corner cases,
// then random fill, drain or churn segments, in bursts with random gaps.
// ---------------------------------------------------------------------------
module stack_alu_unit_test;
    import sau_pkg::*;

    localparam int RANDOM_WORDS = 1800;
    localparam int CYCLE_LIMIT  = 800000;

    typedef enum int {
        PROFILE_FILL,
        PROFILE_DRAIN,
        PROFILE_MIXED
    } t_profile;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  cmd_word = '0;
    logic done;
    t_out result;
    int   fail_count;
    int   outstanding;
    int   cycle_count = 0;
    int   burst_left = 0;

    always #6 i_clk = ~i_clk;

    stack_alu_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (cmd_word),
        .o_done  (done),
        .o_out   (result)
    );

    stack_alu_unit_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_in      (cmd_word),
        .o_done    (done),
        .o_out     (result),
        .o_errors  (fail_count),
        .o_pending (outstanding)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Holds start until the word is taken, then either keeps start high for
    // the next word of the burst or drops it for a random gap.
    task automatic send_word(input t_mode mode, input logic [31:0] value);
        t_in w;
        int  gap;
        w.mode       = mode;
        w.push_value = value;
        cmd_word <= w;
        start    <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0, 1, 2: return 32'($signed($urandom_range(0, 6)) - 3);
            3: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    3: return 32'h0000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic t_mode pick_mode(input t_profile profile);
        int roll;
        int push_pct;
        int pop_pct;
        roll = $urandom_range(0, 99);
        case (profile)
            PROFILE_FILL: begin
                push_pct = 85;
                pop_pct  = 5;
            end
            PROFILE_DRAIN: begin
                push_pct = 15;
                pop_pct  = 30;
            end
            default: begin
                push_pct = 45;
                pop_pct  = 15;
            end
        endcase
        if (roll < push_pct) begin
            return MODE_PUSH;
        end else if (roll < push_pct + pop_pct) begin
            return MODE_POP;
        end
        return t_mode'($urandom_range(MODE_SWAP, MODE_DIV));
    endfunction

    initial begin
        int       sent;
        int       seg_len;
        t_profile profile;
        sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Errors on an empty or single-entry stack, then the arithmetic edges.
        send_word(MODE_POP, 32'h1234_5678);
        send_word(MODE_SWAP, 32'h0);
        send_word(MODE_DIV, 32'h0);
        send_word(MODE_PUSH, 32'h8000_0000);
        send_word(MODE_MUL, 32'hffff_ffff);
        send_word(MODE_PUSH, 32'hffff_ffff);
        send_word(MODE_DIV, 32'h0);             // most negative over minus one
        send_word(MODE_PUSH, 32'h0);
        send_word(MODE_DIV, 32'h0);             // divide by zero
        send_word(MODE_POP, 32'h0);
        send_word(MODE_PUSH, 32'h7fff_ffff);
        send_word(MODE_SUB, 32'h0);
        send_word(MODE_PUSH, 32'hffff_fff9);
        send_word(MODE_PUSH, 32'h0000_0002);
        send_word(MODE_DIV, 32'h0);             // truncation toward zero
        send_word(MODE_MUL, 32'h0);
        send_word(MODE_PUSH, 32'h7fff_ffff);
        send_word(MODE_MUL, 32'h0);
        send_word(MODE_PUSH, 32'h0000_0005);
        send_word(MODE_SWAP, 32'hffff_ffff);
        send_word(MODE_SUB, 32'h0);
        send_word(t_mode'(3'd6), 32'hffff_ffff);
        send_word(t_mode'(3'd7), 32'h0);
        send_word(MODE_POP, 32'h0);
        send_word(MODE_POP, 32'h0);

        // Random segments; fill segments push the stack into the full case.
        profile = PROFILE_FILL;
        while (sent < RANDOM_WORDS) begin
            seg_len = $urandom_range(30, 150);
            repeat (seg_len) begin
                send_word(pick_mode(profile), pick_operand());
                sent++;
            end
            profile = t_profile'($urandom_range(PROFILE_FILL, PROFILE_MIXED));
        end

        if (burst_left > 0) begin
            start <= 1'b0;
        end
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
